### rtl/blend_weight_map_sampler_assert.svh
// Assertion macros used by the block's RTL file blend_weight_map_sampler.sv.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BLEND_WEIGHT_MAP_SAMPLER_ASSERT_SVH
`define BLEND_WEIGHT_MAP_SAMPLER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define BWMS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BWMS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bwms_pkg.sv
package bwms_pkg;

    localparam int DIM_W          = 9;
    localparam int BYTE_W         = 8;
    localparam int WT_W           = 16;
    localparam int POS_W          = 19;
    localparam int FRAC_W         = 16;
    localparam int NUM_CH         = 4;
    localparam int TEXEL_W        = NUM_CH * WT_W;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Shared divider: 24-bit dividend, 10-bit divisor, four quotient bits a cycle.
    localparam int DIV_W    = 24;
    localparam int DVS_W    = 10;
    localparam int DIV_STEP = 4;

    localparam logic [WT_W-1:0]   ONE_Q15 = 16'h8000;
    localparam logic [FRAC_W:0]   ONE_Q16 = 17'h10000;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

### rtl/bwms_ram.sv
module bwms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bwms_div.sv
module bwms_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bwms_pkg::div_req_t req,
    output bwms_pkg::div_rsp_t rsp
);

    localparam int STEPS = bwms_pkg::DIV_W / bwms_pkg::DIV_STEP;
    localparam int CNT_W = $clog2(STEPS);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [bwms_pkg::DIV_W-1:0]    quo_reg, quo_next;
    logic [bwms_pkg::DVS_W-1:0]    rem_reg, rem_next;
    logic [bwms_pkg::DVS_W-1:0]    dvs_reg, dvs_next;

    logic [bwms_pkg::DIV_W-1:0]    step_quo;
    logic [bwms_pkg::DVS_W-1:0]    step_rem;
    logic [bwms_pkg::DVS_W:0]      step_tmp;

    // Restoring division: the dividend shifts out at the top while the
    // quotient bits shift in at the bottom of the same register.
    always_comb
    begin
        step_quo = quo_reg;
        step_rem = rem_reg;
        step_tmp = '0;
        for (int i = 0; i < bwms_pkg::DIV_STEP; i++)
        begin
            step_tmp = {step_rem, step_quo[bwms_pkg::DIV_W-1]};
            step_quo = {step_quo[bwms_pkg::DIV_W-2:0], 1'b0};
            if (step_tmp >= {1'b0, dvs_reg})
            begin
                step_tmp    = step_tmp - {1'b0, dvs_reg};
                step_quo[0] = 1'b1;
            end
            step_rem = step_tmp[bwms_pkg::DVS_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = step_quo;
            rem_next = step_rem;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/blend_weight_map_sampler.sv
// Load request: the shared divider resolves four quotient bits a cycle and runs once for the
// position, then once per channel unless the texel's channels sum to zero (weights then zero).
// Sample request: three texels are read inside a cell, one on the far edge, none outside; one
// shared 18x17 multiplier scales the coordinates and then forms the twelve interpolation products.
// One request is in flight at a time; a finished result waits in the output register.
// Reset (rst_n, asynchronous, active low) clears control and the load counter, sizes go to 256.
module blend_weight_map_sampler #(
    parameter int MAX_WIDTH  = bwms_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bwms_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bwms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bwms_pkg::DIM_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [bwms_pkg::BYTE_W-1:0]       red_byte,
    input  logic [bwms_pkg::BYTE_W-1:0]       green_byte,
    input  logic [bwms_pkg::BYTE_W-1:0]       blue_byte,
    input  logic [bwms_pkg::BYTE_W-1:0]       alpha_byte,
    input  logic signed [bwms_pkg::POS_W-1:0] pos_x,
    input  logic signed [bwms_pkg::POS_W-1:0] pos_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bwms_pkg::WT_W-1:0]         weight_red,
    output logic [bwms_pkg::WT_W-1:0]         weight_green,
    output logic [bwms_pkg::WT_W-1:0]         weight_blue,
    output logic [bwms_pkg::WT_W-1:0]         weight_alpha,
    output logic                              inside_res
);

`include "blend_weight_map_sampler_assert.svh"

    localparam int DIM_W  = bwms_pkg::DIM_W;
    localparam int WT_W   = bwms_pkg::WT_W;
    localparam int FRAC_W = bwms_pkg::FRAC_W;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int TOT_W  = 2 * DIM_W;
    localparam int CMP_W  = ((AW > TOT_W) ? AW : TOT_W) + 1;
    localparam int SCL_W  = bwms_pkg::POS_W - 1 + DIM_W;
    localparam int MA_W   = bwms_pkg::POS_W - 1;
    localparam int MB_W   = FRAC_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = 2 * WT_W;

    typedef enum logic [16:0] {
        ST_IDLE    = 17'h00001,
        ST_L_START = 17'h00002,
        ST_L_POS   = 17'h00004,
        ST_L_CH    = 17'h00008,
        ST_L_WAIT  = 17'h00010,
        ST_L_WRITE = 17'h00020,
        ST_S_MX    = 17'h00040,
        ST_S_MZ    = 17'h00080,
        ST_S_CAP   = 17'h00100,
        ST_S_CLS   = 17'h00200,
        ST_S_RD1   = 17'h00400,
        ST_S_RD2   = 17'h00800,
        ST_S_RD3   = 17'h01000,
        ST_S_EDGE  = 17'h02000,
        ST_S_MUL   = 17'h04000,
        ST_S_ACC   = 17'h08000,
        ST_S_OUT   = 17'h10000
    } state_t;

    function automatic logic [AW-1:0] map_addr(input logic [DIM_W:0] row,
                                               input logic [DIM_W:0] col);
        map_addr = AW'(32'(row) * 32'(MAX_WIDTH) + 32'(col));
    endfunction

    // Control registers
    state_t                      state_reg, state_next;
    logic [DIM_W-1:0]            width_reg, width_next;
    logic [DIM_W-1:0]            height_reg, height_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  ch_reg, ch_next;
    logic [1:0]                  term_reg, term_next;

    // Payload registers
    logic                        act_reg, act_next;
    logic [bwms_pkg::BYTE_W-1:0] byte_reg [bwms_pkg::NUM_CH];
    logic [bwms_pkg::BYTE_W-1:0] byte_next [bwms_pkg::NUM_CH];
    logic [bwms_pkg::POS_W-1:0]  px_reg, px_next;
    logic [bwms_pkg::POS_W-1:0]  pz_reg, pz_next;
    logic [SCL_W-1:0]            x_reg, x_next;
    logic [SCL_W-1:0]            z_reg, z_next;
    logic [PROD_W-1:0]           prod_reg;
    logic [bwms_pkg::TEXEL_W-1:0] tex_reg [3];
    logic [bwms_pkg::TEXEL_W-1:0] tex_next [3];
    logic [WT_W-1:0]             wt_reg [bwms_pkg::NUM_CH];
    logic [WT_W-1:0]             wt_next [bwms_pkg::NUM_CH];
    logic                        hit_reg, hit_next;
    logic [ACC_W-1:0]            acc_reg, acc_next;
    logic [AW-1:0]               waddr_reg, waddr_next;
    logic [WT_W-1:0]             res_reg [bwms_pkg::NUM_CH];
    logic [WT_W-1:0]             res_next [bwms_pkg::NUM_CH];
    logic                        res_hit_reg, res_hit_next;

    // Combinational helpers
    logic [DIM_W-1:0]            w_eff, h_eff, w_m1, h_m1;
    logic [TOT_W-1:0]            total;
    logic [AW-1:0]               pos_eff;
    logic [CMP_W-1:0]            pos_inc;
    logic [bwms_pkg::DVS_W-1:0]  ch_sum;
    logic [bwms_pkg::BYTE_W-1:0] byte_sel;
    logic [MA_W-1:0]             mul_a;
    logic [MB_W-1:0]             mul_b;
    logic [DIM_W-1:0]            ix, iz;
    logic [FRAC_W-1:0]           fx, fz, fmin, fmax;
    logic                        fx_le;
    logic [SCL_W-1:0]            mx, mz;
    logic                        outside, on_edge;
    logic [AW-1:0]               addr_c, addr_t0, addr_b;
    logic [bwms_pkg::TEXEL_W-1:0] tex_sel;
    logic [MB_W-1:0]             coef_sel;
    logic [WT_W-1:0]             wt_sel;
    logic [ACC_W-1:0]            acc_sum;
    logic [WT_W-1:0]             acc_hi;

    bwms_pkg::div_req_t          div_req;
    bwms_pkg::div_rsp_t          div_rsp;

    logic                        ram_we, ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [bwms_pkg::TEXEL_W-1:0] ram_wdata, ram_rdata;

    bwms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bwms_ram #(
        .WIDTH (bwms_pkg::TEXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sizes in use are clamped to the range the store supports.
    always_comb
    begin
        if (width_reg < DIM_W'(2))
        begin
            w_eff = DIM_W'(2);
        end
        else if ((DIM_W + 2)'(width_reg) > (DIM_W + 2)'(MAX_WIDTH))
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg < DIM_W'(2))
        begin
            h_eff = DIM_W'(2);
        end
        else if ((DIM_W + 2)'(height_reg) > (DIM_W + 2)'(MAX_HEIGHT))
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign w_m1  = w_eff - 1'b1;
    assign h_m1  = h_eff - 1'b1;
    assign total = TOT_W'(w_eff) * TOT_W'(h_eff);

    // A counter left past the map by a resize restarts at the origin.
    assign pos_eff = (CMP_W'(pos_reg) >= CMP_W'(total)) ? '0 : pos_reg;
    assign pos_inc = CMP_W'(pos_eff) + 1'b1;

    assign ch_sum   = bwms_pkg::DVS_W'(byte_reg[0]) + bwms_pkg::DVS_W'(byte_reg[1])
                    + bwms_pkg::DVS_W'(byte_reg[2]) + bwms_pkg::DVS_W'(byte_reg[3]);
    assign byte_sel = byte_reg[ch_reg];

    // Cell geometry from the scaled coordinates.
    assign ix    = x_reg[FRAC_W +: DIM_W];
    assign iz    = z_reg[FRAC_W +: DIM_W];
    assign fx    = x_reg[FRAC_W-1:0];
    assign fz    = z_reg[FRAC_W-1:0];
    assign fx_le = (fx <= fz);
    assign fmin  = fx_le ? fx : fz;
    assign fmax  = fx_le ? fz : fx;
    assign mx    = {w_m1, {FRAC_W{1'b0}}};
    assign mz    = {h_m1, {FRAC_W{1'b0}}};
    assign outside = (x_reg > mx) || (z_reg > mz);
    assign on_edge = (x_reg == mx) || (z_reg == mz);

    assign addr_c  = map_addr({1'b0, iz}, {1'b0, ix});
    assign addr_b  = map_addr({1'b0, iz} + 1'b1, {1'b0, ix} + 1'b1);
    assign addr_t0 = fx_le ? map_addr({1'b0, iz} + 1'b1, {1'b0, ix})
                           : map_addr({1'b0, iz}, {1'b0, ix} + 1'b1);

    // The three terms: the corner opposite the diagonal weighted by the fraction
    // difference, the far corner by the smaller fraction and the near corner by
    // one minus the larger fraction.
    always_comb
    begin
        unique case (term_reg)
            2'd0:
            begin
                tex_sel  = tex_reg[0];
                coef_sel = {1'b0, fmax - fmin};
            end
            2'd1:
            begin
                tex_sel  = tex_reg[1];
                coef_sel = {1'b0, fmin};
            end
            2'd2:
            begin
                tex_sel  = tex_reg[2];
                coef_sel = bwms_pkg::ONE_Q16 - {1'b0, fmax};
            end
            default:
            begin
                tex_sel  = '0;
                coef_sel = '0;
            end
        endcase
    end

    assign wt_sel  = tex_sel[WT_W*ch_reg +: WT_W];
    assign acc_sum = acc_reg + prod_reg[ACC_W-1:0];
    assign acc_hi  = acc_sum[ACC_W-1:FRAC_W];

    // Shared multiplier operands.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        priority case (1'b1)
            (state_reg == ST_S_MX):
            begin
                mul_a = px_reg[MA_W-1:0];
                mul_b = MB_W'(w_m1);
            end
            (state_reg == ST_S_MZ):
            begin
                mul_a = pz_reg[MA_W-1:0];
                mul_b = MB_W'(h_m1);
            end
            (state_reg == ST_S_MUL):
            begin
                mul_a = MA_W'(wt_sel);
                mul_b = coef_sel;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign ram_wdata = {wt_reg[3], wt_reg[2], wt_reg[1], wt_reg[0]};
    assign ram_we    = (state_reg == ST_L_WRITE);

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ch_next        = ch_reg;
        term_next      = term_reg;
        act_next       = act_reg;
        px_next        = px_reg;
        pz_next        = pz_reg;
        x_next         = x_reg;
        z_next         = z_reg;
        hit_next       = hit_reg;
        acc_next       = acc_reg;
        waddr_next     = waddr_reg;
        res_hit_next   = res_hit_reg;
        for (int i = 0; i < bwms_pkg::NUM_CH; i++)
        begin
            byte_next[i] = byte_reg[i];
            wt_next[i]   = wt_reg[i];
            res_next[i]  = res_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            tex_next[i] = tex_reg[i];
        end
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        ram_re           = 1'b0;
        ram_raddr        = addr_c;

        if (cfg_we)
        begin
            unique case (cfg_index)
                bwms_pkg::REG_WIDTH:  width_next  = cfg_data;
                bwms_pkg::REG_HEIGHT: height_next = cfg_data;
                default:              width_next  = width_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = action;
                    byte_next[0] = red_byte;
                    byte_next[1] = green_byte;
                    byte_next[2] = blue_byte;
                    byte_next[3] = alpha_byte;
                    px_next      = pos_x;
                    pz_next      = pos_z;
                    state_next   = (action == bwms_pkg::ACT_LOAD) ? ST_L_START : ST_S_MX;
                end
            end
            ST_L_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = bwms_pkg::DIV_W'(pos_eff);
                div_req.divisor  = bwms_pkg::DVS_W'(w_eff);
                pos_next   = (pos_inc >= CMP_W'(total)) ? '0 : AW'(pos_inc);
                state_next = ST_L_POS;
            end
            ST_L_POS:
            begin
                if (div_rsp.done)
                begin
                    // Rows arrive top first, the map stores them bottom first.
                    waddr_next = map_addr(
                        {1'b0, h_m1 - div_rsp.quotient[DIM_W-1:0]},
                        {1'b0, div_rsp.remainder[DIM_W-1:0]});
                    ch_next    = '0;
                    state_next = ST_L_CH;
                end
            end
            ST_L_CH:
            begin
                if (ch_sum == '0)
                begin
                    for (int i = 0; i < bwms_pkg::NUM_CH; i++)
                    begin
                        wt_next[i] = '0;
                    end
                    state_next = ST_L_WRITE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = bwms_pkg::DIV_W'({byte_sel,
                                           (WT_W-1)'(ch_sum >> 1)});
                    div_req.divisor  = ch_sum;
                    state_next       = ST_L_WAIT;
                end
            end
            ST_L_WAIT:
            begin
                if (div_rsp.done)
                begin
                    wt_next[ch_reg] = div_rsp.quotient[WT_W-1:0];
                    ch_next         = ch_reg + 1'b1;
                    state_next      = (ch_reg == 2'd3) ? ST_L_WRITE : ST_L_CH;
                end
            end
            ST_L_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_S_MX:
            begin
                if (px_reg[bwms_pkg::POS_W-1] || pz_reg[bwms_pkg::POS_W-1])
                begin
                    for (int i = 0; i < bwms_pkg::NUM_CH; i++)
                    begin
                        wt_next[i] = '0;
                    end
                    hit_next   = 1'b0;
                    state_next = ST_S_OUT;
                end
                else
                begin
                    state_next = ST_S_MZ;
                end
            end
            ST_S_MZ:
            begin
                x_next     = prod_reg[SCL_W-1:0];
                state_next = ST_S_CAP;
            end
            ST_S_CAP:
            begin
                z_next     = prod_reg[SCL_W-1:0];
                state_next = ST_S_CLS;
            end
            ST_S_CLS:
            begin
                if (outside)
                begin
                    for (int i = 0; i < bwms_pkg::NUM_CH; i++)
                    begin
                        wt_next[i] = '0;
                    end
                    hit_next   = 1'b0;
                    state_next = ST_S_OUT;
                end
                else if (on_edge)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = addr_c;
                    hit_next   = 1'b1;
                    state_next = ST_S_EDGE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = addr_t0;
                    hit_next   = 1'b1;
                    state_next = ST_S_RD1;
                end
            end
            ST_S_RD1:
            begin
                tex_next[0] = ram_rdata;
                ram_re      = 1'b1;
                ram_raddr   = addr_b;
                state_next  = ST_S_RD2;
            end
            ST_S_RD2:
            begin
                tex_next[1] = ram_rdata;
                ram_re      = 1'b1;
                ram_raddr   = addr_c;
                state_next  = ST_S_RD3;
            end
            ST_S_RD3:
            begin
                tex_next[2] = ram_rdata;
                ch_next     = '0;
                term_next   = '0;
                acc_next    = ACC_W'(bwms_pkg::ONE_Q15);
                state_next  = ST_S_MUL;
            end
            ST_S_EDGE:
            begin
                for (int i = 0; i < bwms_pkg::NUM_CH; i++)
                begin
                    wt_next[i] = ram_rdata[WT_W*i +: WT_W];
                end
                state_next = ST_S_OUT;
            end
            ST_S_MUL:
            begin
                state_next = ST_S_ACC;
            end
            ST_S_ACC:
            begin
                if (term_reg == 2'd2)
                begin
                    // The accumulator starts at one half, so the top half is rounded.
                    wt_next[ch_reg] = (acc_hi > bwms_pkg::ONE_Q15) ? bwms_pkg::ONE_Q15 : acc_hi;
                    acc_next   = ACC_W'(bwms_pkg::ONE_Q15);
                    term_next  = '0;
                    ch_next    = ch_reg + 1'b1;
                    state_next = (ch_reg == 2'd3) ? ST_S_OUT : ST_S_MUL;
                end
                else
                begin
                    acc_next   = acc_sum;
                    term_next  = term_reg + 1'b1;
                    state_next = ST_S_MUL;
                end
            end
            ST_S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    for (int i = 0; i < bwms_pkg::NUM_CH; i++)
                    begin
                        res_next[i] = wt_reg[i];
                    end
                    res_hit_next   = hit_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= DIM_W'(256);
            height_reg    <= DIM_W'(256);
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            term_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
            term_reg      <= term_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        px_reg      <= px_next;
        pz_reg      <= pz_next;
        x_reg       <= x_next;
        z_reg       <= z_next;
        hit_reg     <= hit_next;
        acc_reg     <= acc_next;
        waddr_reg   <= waddr_next;
        res_hit_reg <= res_hit_next;
        for (int i = 0; i < bwms_pkg::NUM_CH; i++)
        begin
            byte_reg[i] <= byte_next[i];
            wt_reg[i]   <= wt_next[i];
            res_reg[i]  <= res_next[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            tex_reg[i] <= tex_next[i];
        end
    end

    assign out_valid    = out_valid_reg;
    assign weight_red   = res_reg[0];
    assign weight_green = res_reg[1];
    assign weight_blue  = res_reg[2];
    assign weight_alpha = res_reg[3];
    assign inside_res   = res_hit_reg;

    `BWMS_ASSERT_IMP(a_store_write_on_load, ram_we, act_reg == bwms_pkg::ACT_LOAD,
        "texel store written outside a load")
    `BWMS_ASSERT_IMP(a_pos_within_map, state_reg == ST_L_WRITE,
        CMP_W'(pos_reg) < CMP_W'(total), "load counter beyond the map")
    `BWMS_ASSERT_IMP(a_outside_is_zero, out_valid && !inside_res,
        weight_red == '0 && weight_green == '0 && weight_blue == '0 && weight_alpha == '0,
        "outside result carries non-zero weights")
    `BWMS_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy,
        "divider started while busy")
    `BWMS_ASSERT_NXT(a_pending_result_kept, state_reg == ST_S_OUT && out_valid && !out_ready,
        state_reg == ST_S_OUT, "finished sample left while the output was occupied")

endmodule
